### rtl/core/ttfm_pkg.sv
// ----------------------------------------------------------------------------
// ttfm_pkg - thermal throttle and fan manager shared definitions
// Thresholds, register indexes, widths and the structs passed between the
// clock target unit, the state unit and the top level.
// ----------------------------------------------------------------------------
package ttfm_pkg;

	// field widths
	localparam int TEMP_IN_W  = 9;
	localparam int TEMP_W     = 8;
	localparam int MHZ_W      = 12;
	localparam int FAN_W      = 7;
	localparam int SUBMIT_W   = 32;
	localparam int CNT_OUT_W  = 32;

	// default width of the event counters
	localparam int COUNT_WIDTH_DEF = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_CLOCK  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST_CLOCK = 1'b1;

	// configuration reset values
	localparam logic [MHZ_W-1:0] BASE_CLOCK_RST  = 12'd1000;
	localparam logic [MHZ_W-1:0] BOOST_CLOCK_RST = 12'd2000;

	// temperature thresholds in degrees C
	localparam logic [TEMP_W-1:0] TEMP_CLAMP_MAX    = 8'd150;
	localparam logic [TEMP_W-1:0] TEMP_EMERGENCY    = 8'd105;
	localparam logic [TEMP_W-1:0] TEMP_THROTTLE_ON  = 8'd85;
	localparam logic [TEMP_W-1:0] TEMP_THROTTLE_OFF = 8'd80;

	// clock scaling: percent steps of ten, so the scale is steps / 10
	localparam int PCT_FULL        = 100;
	localparam int PCT_FLOOR       = 30;
	localparam int PCT_STEP        = 10;
	localparam int CLK_STEPS_MAX   = PCT_FULL / PCT_STEP;
	localparam int CLK_STEPS_MIN   = PCT_FLOOR / PCT_STEP;

	// submissions needed since the last recompute before boosting above base
	localparam logic [SUBMIT_W-1:0] LIGHT_LOAD_SUBMITS = 32'd10;

	// clock target result
	typedef struct packed {
		logic [MHZ_W-1:0] target;
		logic             update;
		logic             reject;
	} calc_t;

	// one result beat before packing
	typedef struct packed {
		logic [TEMP_W-1:0]    max_temp_c;
		logic                 emergency_halt;
		logic                 throttle_on;
		logic [MHZ_W-1:0]     gpu_clock_mhz;
		logic                 clock_rejected;
		logic [FAN_W-1:0]     fan_percent;
		logic [CNT_OUT_W-1:0] throttle_events;
		logic [CNT_OUT_W-1:0] throttle_exits;
		logic [CNT_OUT_W-1:0] emergency_events;
		logic [CNT_OUT_W-1:0] clock_changes;
		logic [CNT_OUT_W-1:0] fan_changes;
	} result_t;

endpackage

### rtl/core/ttfm_clock_calc.sv
// ----------------------------------------------------------------------------
// ttfm_clock_calc - clock target computation
// Scales the boost clock by the throttle percentage, caps it at base under
// light load and checks it against the base..boost window.
// ----------------------------------------------------------------------------
module ttfm_clock_calc (
	input  logic [ttfm_pkg::TEMP_W-1:0]   temp_c,
	input  logic [ttfm_pkg::SUBMIT_W-1:0] submit_count,
	input  logic [ttfm_pkg::SUBMIT_W-1:0] submits_seen,
	input  logic [ttfm_pkg::MHZ_W-1:0]    clock_now,
	input  logic [ttfm_pkg::MHZ_W-1:0]    base_clock_mhz,
	input  logic [ttfm_pkg::MHZ_W-1:0]    boost_clock_mhz,
	output ttfm_pkg::calc_t               calc
);
	import ttfm_pkg::*;

	localparam int SCALED_W = 16;
	// floor(x / 10) = (x * 52429) >> 19 for x below 43690
	localparam logic [SCALED_W-1:0] DIV10_RECIP = 16'd52429;
	localparam int DIV10_SHIFT = 19;
	localparam logic [TEMP_W-1:0] TEMP_AT_FLOOR =
		TEMP_THROTTLE_ON + TEMP_W'(CLK_STEPS_MAX - CLK_STEPS_MIN);
	localparam logic [TEMP_W-1:0] TEMP_STEP_BASE = TEMP_THROTTLE_ON + TEMP_W'(CLK_STEPS_MAX);

	logic                     throttled;
	logic [3:0]               steps;
	logic [SCALED_W-1:0]      boost_w;
	logic [SCALED_W-1:0]      scaled;
	logic [2*SCALED_W-1:0]    prod;
	logic [MHZ_W-1:0]         quot;
	logic [MHZ_W-1:0]         raw_target;
	logic [SUBMIT_W-1:0]      submit_delta;
	logic                     light_load;
	logic [MHZ_W-1:0]         target;
	logic                     out_of_range;
	logic                     differs;

	// tenths of boost kept, one step less per degree over the throttle point
	always_comb begin
		throttled = (temp_c >= TEMP_THROTTLE_ON);
		if (temp_c >= TEMP_AT_FLOOR) begin
			steps = 4'(CLK_STEPS_MIN);
		end else begin
			steps = 4'(TEMP_STEP_BASE - temp_c);
		end
	end

	// boost times steps by shifts, adds and one subtract
	assign boost_w = SCALED_W'(boost_clock_mhz);

	always_comb begin
		unique case (steps)
			4'd3:    scaled = (boost_w << 1) + boost_w;
			4'd4:    scaled = boost_w << 2;
			4'd5:    scaled = (boost_w << 2) + boost_w;
			4'd6:    scaled = (boost_w << 2) + (boost_w << 1);
			4'd7:    scaled = (boost_w << 3) - boost_w;
			4'd8:    scaled = boost_w << 3;
			4'd9:    scaled = (boost_w << 3) + boost_w;
			4'd10:   scaled = (boost_w << 3) + (boost_w << 1);
			default: scaled = '0;
		endcase
	end

	// divide by ten through the reciprocal
	assign prod = {{SCALED_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, DIV10_RECIP};
	assign quot = prod[DIV10_SHIFT +: MHZ_W];

	// light load cap and window check
	always_comb begin
		raw_target   = throttled ? quot : boost_clock_mhz;
		submit_delta = submit_count - submits_seen;
		light_load   = (submit_delta < LIGHT_LOAD_SUBMITS);
		if (light_load && (raw_target > base_clock_mhz)) begin
			target = base_clock_mhz;
		end else begin
			target = raw_target;
		end
		out_of_range = (target < base_clock_mhz) || (target > boost_clock_mhz);
		differs      = (target != clock_now);
		calc.target  = target;
		calc.update  = differs && !out_of_range;
		calc.reject  = differs && out_of_range;
	end

endmodule

### rtl/core/ttfm_state.sv
// ----------------------------------------------------------------------------
// ttfm_state - throttle, clock, fan and counter state
// Applies one temperature tick to the hysteresis flag, tracked clock, fan
// duty and event counters, and presents the values after the tick.
// ----------------------------------------------------------------------------
module ttfm_state #(
	parameter int COUNT_WIDTH = ttfm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [ttfm_pkg::TEMP_W-1:0]   temp_c,
	input  logic [ttfm_pkg::SUBMIT_W-1:0] submit_count,
	input  logic [ttfm_pkg::MHZ_W-1:0]    base_clock_mhz,
	input  logic [ttfm_pkg::MHZ_W-1:0]    boost_clock_mhz,
	output ttfm_pkg::result_t             res
);
	import ttfm_pkg::*;

	localparam int CNT_NUM      = 5;
	localparam int CNT_THROTTLE = 0;
	localparam int CNT_EXIT     = 1;
	localparam int CNT_EMERG    = 2;
	localparam int CNT_CLOCK    = 3;
	localparam int CNT_FAN      = 4;

	localparam logic [TEMP_W-1:0] FAN_T_LOW  = 8'd50;
	localparam logic [TEMP_W-1:0] FAN_T_MID  = 8'd70;
	localparam logic [FAN_W-1:0]  FAN_IDLE   = 7'd20;
	localparam logic [FAN_W-1:0]  FAN_MID    = 7'd60;
	localparam logic [FAN_W-1:0]  FAN_FULL   = 7'd100;
	localparam logic [7:0]        FAN_BAND   = 8'd5;
	// floor(x / 3) = (x * 43) >> 7 for x up to 56
	localparam logic [5:0]        DIV3_RECIP = 6'd43;
	localparam int                DIV3_SHIFT = 7;

	logic                   flag_q;
	logic [MHZ_W-1:0]       clock_q;
	logic [FAN_W-1:0]       fan_q;
	logic [SUBMIT_W-1:0]    seen_q;
	logic [COUNT_WIDTH-1:0] cnt_q    [CNT_NUM];
	logic [COUNT_WIDTH-1:0] cnt_next [CNT_NUM];
	logic [1:0]             cnt_inc  [CNT_NUM];
	logic [CNT_OUT_W-1:0]   cnt_out  [CNT_NUM];

	calc_t                  calc;
	logic                   halt;
	logic                   entry;
	logic                   leave;
	logic                   recompute;
	logic                   flag_next;
	logic [MHZ_W-1:0]       clock_next;
	logic [FAN_W-1:0]       fan_target;
	logic [FAN_W-1:0]       fan_next;
	logic                   fan_update;
	logic [3:0]             mid_deg;
	logic [5:0]             mid_x4;
	logic [11:0]            mid_prod;

	ttfm_clock_calc u_clock_calc (
		.temp_c          (temp_c),
		.submit_count    (submit_count),
		.submits_seen    (seen_q),
		.clock_now       (clock_q),
		.base_clock_mhz  (base_clock_mhz),
		.boost_clock_mhz (boost_clock_mhz),
		.calc            (calc)
	);

	// piecewise fan curve
	always_comb begin
		mid_deg  = 4'(temp_c - FAN_T_MID);
		mid_x4   = {mid_deg, 2'b00};
		mid_prod = 12'(mid_x4) * 12'(DIV3_RECIP);
		if (temp_c < FAN_T_LOW) begin
			fan_target = FAN_IDLE;
		end else if (temp_c < FAN_T_MID) begin
			fan_target = FAN_W'(temp_c - 8'd10);
		end else if (temp_c < TEMP_THROTTLE_ON) begin
			fan_target = FAN_MID + FAN_W'(mid_prod >> DIV3_SHIFT);
		end else if (temp_c < TEMP_EMERGENCY) begin
			fan_target = FAN_W'(temp_c - 8'd5);
		end else begin
			fan_target = FAN_FULL;
		end
	end

	// tick decisions
	always_comb begin
		halt      = (temp_c >= TEMP_EMERGENCY);
		entry     = !halt && (temp_c >= TEMP_THROTTLE_ON) && !flag_q;
		leave     = !halt && (temp_c <= TEMP_THROTTLE_OFF) && flag_q;
		recompute = entry || leave;
		flag_next = entry ? 1'b1 : (leave ? 1'b0 : flag_q);

		clock_next = (recompute && calc.update) ? calc.target : clock_q;

		fan_update = !halt && ((8'(fan_target) > 8'(fan_q) + FAN_BAND) ||
			(8'(fan_q) > 8'(fan_target) + FAN_BAND));
		fan_next   = fan_update ? fan_target : fan_q;

		// entry counts once for itself and once for the throttled recompute
		cnt_inc[CNT_THROTTLE] = halt ? 2'd1 : (entry ? 2'd2 : 2'd0);
		cnt_inc[CNT_EXIT]     = {1'b0, leave};
		cnt_inc[CNT_EMERG]    = {1'b0, halt};
		cnt_inc[CNT_CLOCK]    = {1'b0, recompute && calc.update};
		cnt_inc[CNT_FAN]      = {1'b0, fan_update};
	end

	// counters and their low output bits
	for (genvar i = 0; i < CNT_NUM; i++) begin : g_cnt
		assign cnt_next[i] = cnt_q[i] + COUNT_WIDTH'(cnt_inc[i]);
		if (COUNT_WIDTH >= CNT_OUT_W) begin : g_cut
			assign cnt_out[i] = cnt_next[i][CNT_OUT_W-1:0];
		end else begin : g_ext
			assign cnt_out[i] = {{(CNT_OUT_W-COUNT_WIDTH){1'b0}}, cnt_next[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (advance) begin
				cnt_q[i] <= cnt_next[i];
			end
		end
	end

	// flag, clock, fan and submission marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= 1'b0;
			clock_q <= '0;
			fan_q   <= '0;
			seen_q  <= '0;
		end else if (advance) begin
			flag_q  <= flag_next;
			clock_q <= clock_next;
			fan_q   <= fan_next;
			if (recompute) begin
				seen_q <= submit_count;
			end
		end
	end

	// values after the tick
	always_comb begin
		res.max_temp_c       = temp_c;
		res.emergency_halt   = halt;
		res.throttle_on      = flag_next;
		res.gpu_clock_mhz    = clock_next;
		res.clock_rejected   = recompute && calc.reject;
		res.fan_percent      = fan_next;
		res.throttle_events  = cnt_out[CNT_THROTTLE];
		res.throttle_exits   = cnt_out[CNT_EXIT];
		res.emergency_events = cnt_out[CNT_EMERG];
		res.clock_changes    = cnt_out[CNT_CLOCK];
		res.fan_changes      = cnt_out[CNT_FAN];
	end

endmodule

### rtl/core/thermal_throttle_fan_manager.sv
// ----------------------------------------------------------------------------
// thermal_throttle_fan_manager - thermal throttle and fan control
// Takes temperature ticks and returns throttle, clock, fan and event status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per beat: edge and junction temperatures and the
//   running submission count. m_axis returns one status beat per tick:
//   hottest clamped temperature, emergency halt, throttle flag, tracked
//   clock, clock reject, fan duty and five wrapping event counters.
//   cfg_wr_en/cfg_index/cfg_wdata write the base and boost clocks; write
//   them only while no tick is in flight.
//   Path: a tick accepted on s_axis is captured in the input stage, and its
//   status beat is registered in the output register and shown on m_axis
//   once the output register is free or draining.
//   Throughput: one tick per cycle while m_axis is not stalled; the state of
//   each tick is updated in the same cycle that moves it from the input stage to the output register.
//   Reset clears all state and counters, the clock and fan to zero, and sets
//   base to 1000 MHz and boost to 2000 MHz.
//   When m_axis stalls the output register holds its beat; the input stage
//   still takes one more tick, then s_axis_tready drops until the output
//   frees up.
// ----------------------------------------------------------------------------
module thermal_throttle_fan_manager #(
	parameter int COUNT_WIDTH = ttfm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wr_en,
	input  logic [ttfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttfm_pkg::MHZ_W-1:0]     cfg_wdata,
	// tick input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// edge_temp_c[8:0], junction_temp_c[17:9], submit_count[49:18], zero pad
	input  logic [55:0]                    s_axis_tdata,
	// status output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// max_temp_c[7:0], emergency_halt[8], throttle_on[9], gpu_clock_mhz[21:10],
	// clock_rejected[22], fan_percent[29:23], throttle_events[61:30],
	// throttle_exits[93:62], emergency_events[125:94], clock_changes[157:126],
	// fan_changes[189:158], zero pad
	output logic [191:0]                   m_axis_tdata
);
	import ttfm_pkg::*;

	logic [MHZ_W-1:0]     base_q;
	logic [MHZ_W-1:0]     boost_q;

	logic                 valid_s1;
	logic [TEMP_IN_W-1:0] edge_s1;
	logic [TEMP_IN_W-1:0] junction_s1;
	logic [SUBMIT_W-1:0]  submit_s1;

	logic                 out_valid_q;
	logic [191:0]         out_data_q;

	logic                 advance;
	logic [TEMP_W-1:0]    edge_clamped;
	logic [TEMP_W-1:0]    junction_clamped;
	logic [TEMP_W-1:0]    max_temp;
	result_t              res;

	// clamp a signed reading to 0..150
	function automatic logic [TEMP_W-1:0] clamp_temp(input logic [TEMP_IN_W-1:0] raw);
		logic [TEMP_W-1:0] v;
		v = raw[TEMP_W-1:0];
		if (raw[TEMP_IN_W-1]) begin
			return '0;
		end else if (v > TEMP_CLAMP_MAX) begin
			return TEMP_CLAMP_MAX;
		end else begin
			return v;
		end
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_CLOCK_RST;
			boost_q <= BOOST_CLOCK_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_CLOCK:  base_q  <= cfg_wdata;
				REG_BOOST_CLOCK: boost_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: a tick moves on when the output register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			edge_s1     <= s_axis_tdata[8:0];
			junction_s1 <= s_axis_tdata[17:9];
			submit_s1   <= s_axis_tdata[49:18];
		end
	end

	// hottest clamped reading
	always_comb begin
		edge_clamped     = clamp_temp(edge_s1);
		junction_clamped = clamp_temp(junction_s1);
		max_temp = (junction_clamped > edge_clamped) ? junction_clamped : edge_clamped;
	end

	ttfm_state #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.temp_c          (max_temp),
		.submit_count    (submit_s1),
		.base_clock_mhz  (base_q),
		.boost_clock_mhz (boost_q),
		.res             (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00,
				res.fan_changes,
				res.clock_changes,
				res.emergency_events,
				res.throttle_exits,
				res.throttle_events,
				res.fan_percent,
				res.clock_rejected,
				res.gpu_clock_mhz,
				res.throttle_on,
				res.emergency_halt,
				res.max_temp_c};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
